// File: hdl/nearest_neighbor_scale_address_gen_defines.svh
// Assertion macros shared by the address generator.
`ifndef NEAREST_NEIGHBOR_SCALE_ADDRESS_GEN_DEFINES_SVH
`define NEAREST_NEIGHBOR_SCALE_ADDRESS_GEN_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define NNSAG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nnsag: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define NNSAG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nnsag: next-cycle check failed");
`else
`define NNSAG_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define NNSAG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/nnsag_pkg.sv
package nnsag_pkg;

  localparam int DimW     = 13;
  localparam int CoordW   = 12;
  localparam int StrideW  = 16;
  localparam int OffW     = 28;
  localparam int ChW      = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam int MaxDimDefault = 4096;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SRC_WIDTH      = 3'd0,
    CFG_SRC_HEIGHT     = 3'd1,
    CFG_SRC_ROW_STRIDE = 3'd2,
    CFG_DST_WIDTH      = 3'd3,
    CFG_DST_HEIGHT     = 3'd4,
    CFG_DST_ROW_STRIDE = 3'd5,
    CFG_CHANNEL_COUNT  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_STEP
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic div_start;   // load both dividers
    logic frame_init;  // latch steps, clear counters
    logic emit;        // load result register and advance
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_busy;
  } status_t;

endpackage

// File: hdl/nnsag_div.sv
module nnsag_div
  import nnsag_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DimW-1:0] dividend_i,
  input  logic [DimW-1:0] divisor_i,
  output logic            busy_o,
  output logic [DimW-1:0] quotient_o,
  output logic [DimW-1:0] remainder_o
);

  localparam int CntW = $clog2(DimW + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DimW-1:0] rem_q, rem_d;
  logic [DimW-1:0] quo_q, quo_d;
  logic [DimW-1:0] den_q, den_d;
  logic [DimW:0]   shifted;
  logic [DimW:0]   diff;
  logic            fits;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    shifted = {rem_q, quo_q[DimW-1]};
    fits    = shifted >= {1'b0, den_q};
    diff    = shifted - {1'b0, den_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DimW);
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
      rem_d = fits ? diff[DimW-1:0] : shifted[DimW-1:0];
      quo_d = {quo_q[DimW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: hdl/nnsag_ctrl.sv
module nnsag_ctrl
  import nnsag_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    restart_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output cmd_t    cmd_o,
  input  status_t status_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  always_comb begin
    out_free   = !out_valid_q || !out_stall_i;
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (restart_i) begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end else if (out_free) begin
            cmd_o.emit = 1'b1;
          end else begin
            state_d = ST_STEP;
          end
        end
      end
      ST_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.frame_init = 1'b1;
          state_d          = ST_STEP;
        end
      end
      ST_STEP: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // Hold a stalled result, drop it once taken.
    out_valid_d = cmd_o.emit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/nnsag_datapath.sv
module nnsag_datapath
  import nnsag_pkg::*;
#(
  parameter int MAX_DIM = MaxDimDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  output logic [OffW-1:0]     src_offset_o,
  output logic [OffW-1:0]     dst_offset_o,
  output logic [CoordW-1:0]   dst_x_o,
  output logic [CoordW-1:0]   dst_y_o,
  output logic                frame_last_o
);

  localparam int DimAllOnes = (1 << DimW) - 1;
  localparam logic [DimW-1:0] DimCap =
    DimW'((MAX_DIM > DimAllOnes) ? DimAllOnes : MAX_DIM);

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimCap) begin
      r = DimCap;
    end
    return r;
  endfunction

  // Configuration registers.
  logic [DimW-1:0]    src_width_q, src_height_q, dst_width_q, dst_height_q;
  logic [StrideW-1:0] src_stride_q, dst_stride_q;
  logic [ChW-1:0]     channel_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q     <= DimW'(1);
      src_height_q    <= DimW'(1);
      src_stride_q    <= StrideW'(1);
      dst_width_q     <= DimW'(1);
      dst_height_q    <= DimW'(1);
      dst_stride_q    <= StrideW'(1);
      channel_count_q <= ChW'(3);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SRC_WIDTH:      src_width_q     <= cfg_data_i[DimW-1:0];
        CFG_SRC_HEIGHT:     src_height_q    <= cfg_data_i[DimW-1:0];
        CFG_SRC_ROW_STRIDE: src_stride_q    <= cfg_data_i[StrideW-1:0];
        CFG_DST_WIDTH:      dst_width_q     <= cfg_data_i[DimW-1:0];
        CFG_DST_HEIGHT:     dst_height_q    <= cfg_data_i[DimW-1:0];
        CFG_DST_ROW_STRIDE: dst_stride_q    <= cfg_data_i[StrideW-1:0];
        CFG_CHANNEL_COUNT:  channel_count_q <= cfg_data_i[ChW-1:0];
        default: ;
      endcase
    end
  end

  logic [DimW-1:0] sw, sh, dw, dh;
  logic [ChW-1:0]  ch;

  assign sw = clamp_dim(src_width_q);
  assign sh = clamp_dim(src_height_q);
  assign dw = clamp_dim(dst_width_q);
  assign dh = clamp_dim(dst_height_q);
  assign ch = (channel_count_q >= ChW'(4)) ? ChW'(4) : ChW'(3);

  // Step dividers, run once per restart.
  logic            col_busy, row_busy;
  logic [DimW-1:0] col_quo, col_rem, row_quo, row_rem;

  nnsag_div u_col_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (sw),
    .divisor_i   (dw),
    .busy_o      (col_busy),
    .quotient_o  (col_quo),
    .remainder_o (col_rem)
  );

  nnsag_div u_row_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (sh),
    .divisor_i   (dh),
    .busy_o      (row_busy),
    .quotient_o  (row_quo),
    .remainder_o (row_rem)
  );

  assign status_o.div_busy = col_busy || row_busy;

  // Walk state.
  logic [CoordW-1:0] col_count_q, col_count_d, row_count_q, row_count_d;
  logic [CoordW-1:0] src_col_q, src_col_d, src_row_q, src_row_d;
  logic [DimW-1:0]   col_res_q, col_res_d, row_res_q, row_res_d;
  logic [DimW-1:0]   col_whole_q, col_whole_d, col_frac_q, col_frac_d;
  logic [DimW-1:0]   row_whole_q, row_whole_d, row_frac_q, row_frac_d;

  logic              row_end, frame_end;
  logic [DimW:0]     col_sum, row_sum;
  logic [CoordW-1:0] col_pos, row_pos;
  logic [OffW-1:0]   src_off, dst_off;

  always_comb begin
    row_end   = ({1'b0, col_count_q} + 1'b1) >= dw;
    frame_end = row_end && (({1'b0, row_count_q} + 1'b1) >= dh);

    src_off = OffW'(src_row_q) * OffW'(src_stride_q) + OffW'(src_col_q) * OffW'(ch);
    dst_off = OffW'(row_count_q) * OffW'(dst_stride_q) + OffW'(col_count_q) * OffW'(ch);

    // DDA: add whole and fraction, carry once when the residue overflows.
    col_sum = {1'b0, col_res_q} + {1'b0, col_frac_q};
    col_pos = src_col_q + col_whole_q[CoordW-1:0];
    if (col_sum >= {1'b0, dw}) begin
      col_sum = col_sum - {1'b0, dw};
      col_pos = col_pos + 1'b1;
    end
    row_sum = {1'b0, row_res_q} + {1'b0, row_frac_q};
    row_pos = src_row_q + row_whole_q[CoordW-1:0];
    if (row_sum >= {1'b0, dh}) begin
      row_sum = row_sum - {1'b0, dh};
      row_pos = row_pos + 1'b1;
    end

    col_count_d = col_count_q;
    row_count_d = row_count_q;
    src_col_d   = src_col_q;
    src_row_d   = src_row_q;
    col_res_d   = col_res_q;
    row_res_d   = row_res_q;
    col_whole_d = col_whole_q;
    col_frac_d  = col_frac_q;
    row_whole_d = row_whole_q;
    row_frac_d  = row_frac_q;

    if (cmd_i.frame_init) begin
      col_whole_d = col_quo;
      col_frac_d  = col_rem;
      row_whole_d = row_quo;
      row_frac_d  = row_rem;
      col_count_d = '0;
      row_count_d = '0;
      src_col_d   = '0;
      src_row_d   = '0;
      col_res_d   = '0;
      row_res_d   = '0;
    end else if (cmd_i.emit) begin
      if (!row_end) begin
        col_count_d = col_count_q + 1'b1;
        src_col_d   = col_pos;
        col_res_d   = col_sum[DimW-1:0];
      end else begin
        col_count_d = '0;
        src_col_d   = '0;
        col_res_d   = '0;
        if (frame_end) begin
          row_count_d = '0;
          src_row_d   = '0;
          row_res_d   = '0;
        end else begin
          row_count_d = row_count_q + 1'b1;
          src_row_d   = row_pos;
          row_res_d   = row_sum[DimW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
      src_col_q   <= '0;
      src_row_q   <= '0;
      col_res_q   <= '0;
      row_res_q   <= '0;
      col_whole_q <= '0;
      col_frac_q  <= '0;
      row_whole_q <= '0;
      row_frac_q  <= '0;
    end else begin
      col_count_q <= col_count_d;
      row_count_q <= row_count_d;
      src_col_q   <= src_col_d;
      src_row_q   <= src_row_d;
      col_res_q   <= col_res_d;
      row_res_q   <= row_res_d;
      col_whole_q <= col_whole_d;
      col_frac_q  <= col_frac_d;
      row_whole_q <= row_whole_d;
      row_frac_q  <= row_frac_d;
    end
  end

  // Result register.
  logic [OffW-1:0]   src_offset_q, dst_offset_q;
  logic [CoordW-1:0] dst_x_q, dst_y_q;
  logic              frame_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      src_offset_q <= src_off;
      dst_offset_q <= dst_off;
      dst_x_q      <= col_count_q;
      dst_y_q      <= row_count_q;
      frame_last_q <= frame_end;
    end
  end

  assign src_offset_o = src_offset_q;
  assign dst_offset_o = dst_offset_q;
  assign dst_x_o      = dst_x_q;
  assign dst_y_o      = dst_y_q;
  assign frame_last_o = frame_last_q;

endmodule

// File: hdl/nearest_neighbor_scale_address_gen.sv
// Channel   Handshake              Payload
// in        in_valid_i/in_stall_o  restart_i
// out       out_valid_o/out_stall_i src_offset_o, dst_offset_o, dst_x_o, dst_y_o, frame_last_o
// cfg       cfg_we_i               cfg_idx_i, cfg_data_i
//
// A continue item goes straight into the result register while it is free; otherwise it waits in ST_STEP.
// A restart item runs the bit-serial step dividers in ST_DIV, latches the steps, then is emitted from ST_STEP.
// The result register holds its item under out_stall_i; the next item is still accepted.
// Reset clears the walk to pixel zero with zero steps; there is no clearing pass.
`include "nearest_neighbor_scale_address_gen_defines.svh"

module nearest_neighbor_scale_address_gen
  import nnsag_pkg::*;
#(
  parameter int MAX_DIM = MaxDimDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                restart_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OffW-1:0]     src_offset_o,
  output logic [OffW-1:0]     dst_offset_o,
  output logic [CoordW-1:0]   dst_x_o,
  output logic [CoordW-1:0]   dst_y_o,
  output logic                frame_last_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  nnsag_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .restart_i   (restart_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  nnsag_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .src_offset_o (src_offset_o),
    .dst_offset_o (dst_offset_o),
    .dst_x_o      (dst_x_o),
    .dst_y_o      (dst_y_o),
    .frame_last_o (frame_last_o)
  );

  // A new result never overwrites one still waiting downstream.
  `NNSAG_ASSERT_NOW(a_emit_free, clk_i, rst_ni, cmd.emit, !out_valid_o || !out_stall_i)
  // Dividers are idle whenever a result is built or steps are latched.
  `NNSAG_ASSERT_NOW(a_div_idle, clk_i, rst_ni, cmd.emit || cmd.frame_init, !status.div_busy)
  // A divider run starts right after a restart is taken and holds off input.
  `NNSAG_ASSERT_NEXT(a_div_run, clk_i, rst_ni, cmd.div_start, status.div_busy && in_stall_o)

endmodule

// File: bench/nearest_neighbor_scale_address_gen_test.sv
`timescale 1ns / 1ps

module nearest_neighbor_scale_address_gen_test
  import nnsag_pkg::*;
();

  localparam int QuietLimit    = 2000;
  localparam int HoldCycles    = 80;
  localparam int PressurePhase = 3;
  localparam int CalmPhase     = 6;
  localparam int RandomItems   = 1400;

  typedef struct packed {
    logic [OffW-1:0]   src_off;
    logic [OffW-1:0]   dst_off;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic              last;
  } pixel_addr_t;

  // Walks the destination raster and keeps the addresses still owed by the block.
  class resize_walk_board;
    logic [DimW-1:0]    src_w, src_h, dst_w, dst_h;
    logic [StrideW-1:0] src_stride, dst_stride;
    logic [ChW-1:0]     chan_reg;
    logic [CoordW-1:0]  col_n, row_n, src_x, src_y;
    logic [DimW-1:0]    col_res, row_res, col_whole, col_frac, row_whole, row_frac;
    pixel_addr_t        due_q[$];
    int                 errors;

    function new();
      src_w = 1;
      src_h = 1;
      src_stride = 1;
      dst_w = 1;
      dst_h = 1;
      dst_stride = 1;
      chan_reg = 3;
      col_n = 0;
      row_n = 0;
      src_x = 0;
      src_y = 0;
      col_res = 0;
      row_res = 0;
      col_whole = 0;
      col_frac = 0;
      row_whole = 0;
      row_frac = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_SRC_WIDTH:      src_w = data[DimW-1:0];
        CFG_SRC_HEIGHT:     src_h = data[DimW-1:0];
        CFG_SRC_ROW_STRIDE: src_stride = data[StrideW-1:0];
        CFG_DST_WIDTH:      dst_w = data[DimW-1:0];
        CFG_DST_HEIGHT:     dst_h = data[DimW-1:0];
        CFG_DST_ROW_STRIDE: dst_stride = data[StrideW-1:0];
        CFG_CHANNEL_COUNT:  chan_reg = data[ChW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(logic [DimW-1:0] v);
      if (v == 0) return 1;
      if (v > MaxDimDefault) return MaxDimDefault;
      return int'(v);
    endfunction

    // Advance one DDA axis; at most one carry per pixel.
    function void step_axis(inout logic [CoordW-1:0] pos, inout logic [DimW-1:0] res,
                            input logic [DimW-1:0] whole, input logic [DimW-1:0] frac,
                            input int unsigned den);
      int unsigned r;
      int unsigned p;
      r = 32'(res) + 32'(frac);
      p = 32'(pos) + 32'(whole);
      if (r >= den) begin
        r -= den;
        p++;
      end
      res = r[DimW-1:0];
      pos = p[CoordW-1:0];
    endfunction

    function void note_item(bit restart);
      int unsigned sw, sh, dw, dh, ch, src_full, dst_full;
      bit          row_end, frame_end;
      pixel_addr_t want;
      sw = clamp_dim(src_w);
      sh = clamp_dim(src_h);
      dw = clamp_dim(dst_w);
      dh = clamp_dim(dst_h);
      ch = (chan_reg >= 4) ? 4 : 3;
      if (restart) begin
        col_whole = DimW'(sw / dw);
        col_frac = DimW'(sw % dw);
        row_whole = DimW'(sh / dh);
        row_frac = DimW'(sh % dh);
        col_n = 0;
        row_n = 0;
        src_x = 0;
        src_y = 0;
        col_res = 0;
        row_res = 0;
      end
      row_end = (32'(col_n) + 1) >= dw;
      frame_end = row_end && ((32'(row_n) + 1) >= dh);
      src_full = 32'(src_y) * 32'(src_stride) + 32'(src_x) * ch;
      dst_full = 32'(row_n) * 32'(dst_stride) + 32'(col_n) * ch;
      want.src_off = src_full[OffW-1:0];
      want.dst_off = dst_full[OffW-1:0];
      want.col = col_n;
      want.row = row_n;
      want.last = frame_end;
      due_q.push_back(want);
      if (!row_end) begin
        col_n = col_n + 1'b1;
        step_axis(src_x, col_res, col_whole, col_frac, dw);
      end else begin
        col_n = 0;
        src_x = 0;
        col_res = 0;
        if (frame_end) begin
          row_n = 0;
          src_y = 0;
          row_res = 0;
        end else begin
          row_n = row_n + 1'b1;
          step_axis(src_y, row_res, row_whole, row_frac, dh);
        end
      end
    endfunction

    function void report_mismatch(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endfunction

    function void check_result(pixel_addr_t got);
      pixel_addr_t want;
      if (due_q.size() == 0) begin
        report_mismatch($sformatf("result at (%0d,%0d) with nothing outstanding",
                                  got.col, got.row));
        return;
      end
      want = due_q.pop_front();
      if (got.src_off !== want.src_off)
        report_mismatch($sformatf("src_offset %0d, want %0d at (%0d,%0d)",
                                  got.src_off, want.src_off, want.col, want.row));
      if (got.dst_off !== want.dst_off)
        report_mismatch($sformatf("dst_offset %0d, want %0d at (%0d,%0d)",
                                  got.dst_off, want.dst_off, want.col, want.row));
      if (got.col !== want.col)
        report_mismatch($sformatf("dst_x %0d, want %0d", got.col, want.col));
      if (got.row !== want.row)
        report_mismatch($sformatf("dst_y %0d, want %0d", got.row, want.row));
      if (got.last !== want.last)
        report_mismatch($sformatf("frame_last %0b, want %0b at (%0d,%0d)",
                                  got.last, want.last, want.col, want.row));
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                restart_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [OffW-1:0]     src_offset_o;
  logic [OffW-1:0]     dst_offset_o;
  logic [CoordW-1:0]   dst_x_o;
  logic [CoordW-1:0]   dst_y_o;
  logic                frame_last_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  resize_walk_board board;
  int               phase_no;
  bit               calm;

  nearest_neighbor_scale_address_gen u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .src_offset_o (src_offset_o),
    .dst_offset_o (dst_offset_o),
    .dst_x_o      (dst_x_o),
    .dst_y_o      (dst_y_o),
    .frame_last_o (frame_last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    pixel_addr_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.src_off = src_offset_o;
      got.dst_off = dst_offset_o;
      got.col = dst_x_o;
      got.row = dst_y_o;
      got.last = frame_last_o;
      board.check_result(got);
    end
  end

  // Receiver: random stalls except in the calm phase, one long hold-off in the pressure phase.
  initial begin
    bit held_once;
    held_once = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (phase_no == PressurePhase && !held_once) begin
        held_once = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 23);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  // Offer one item and hold it until taken; returns on the following falling edge.
  task automatic send_item(bit restart_flag);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i <= restart_flag;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(restart_flag);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    board.write_reg(idx, data);
  endtask

  task automatic configure(logic [CfgDataW-1:0] sw, logic [CfgDataW-1:0] sh,
                           logic [CfgDataW-1:0] ss, logic [CfgDataW-1:0] dw,
                           logic [CfgDataW-1:0] dh, logic [CfgDataW-1:0] ds,
                           logic [CfgDataW-1:0] ch);
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_SRC_ROW_STRIDE, ss);
    write_reg(CFG_DST_WIDTH, dw);
    write_reg(CFG_DST_HEIGHT, dh);
    write_reg(CFG_DST_ROW_STRIDE, ds);
    write_reg(CFG_CHANNEL_COUNT, ch);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CfgDataW-1:0] odd_dim();
    case ($urandom_range(3))
      0: return 0;
      1: return CfgDataW'(MaxDimDefault);
      2: return 16'h1fff;
      default: return CfgDataW'($urandom);
    endcase
  endfunction

  // Keep destination frames small so most phases wrap several times.
  function automatic logic [CfgDataW-1:0] pick_dst_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return CfgDataW'($urandom_range(1, 12));
    if (r < 92) return CfgDataW'($urandom_range(13, 80));
    return odd_dim();
  endfunction

  function automatic logic [CfgDataW-1:0] pick_src_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return CfgDataW'($urandom_range(1, 16));
    if (r < 85) return CfgDataW'($urandom_range(1, MaxDimDefault));
    return odd_dim();
  endfunction

  function automatic logic [CfgDataW-1:0] pick_stride();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 20) return 16'hffff;
    if (r < 60) return CfgDataW'($urandom_range(1, 256));
    return CfgDataW'($urandom);
  endfunction

  function automatic logic [CfgDataW-1:0] pick_channels();
    if ($urandom_range(99) < 70) return CfgDataW'($urandom_range(3, 4));
    return CfgDataW'($urandom_range(0, 7));
  endfunction

  initial begin
    int sent;
    int n;
    board = new();
    phase_no = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    restart_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_SRC_WIDTH;
    cfg_data_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset registers, no restart yet: zero steps.
    send_item(1'b0);
    send_item(1'b0);
    drain();

    // Still no restart with real sizes, then a full frame and its wrap.
    configure(13, 7, 40, 4, 3, 20, 4);
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    repeat (12) send_item(1'b0);
    drain();

    // Zero and oversized dimensions, zero strides, channel count zero.
    configure(0, 16'h1fff, 0, 0, CfgDataW'(MaxDimDefault), 0, 0);
    send_item(1'b1);
    send_item(1'b0);
    drain();

    // Largest source, widest strides, channel count above four.
    configure(CfgDataW'(MaxDimDefault), CfgDataW'(MaxDimDefault), 16'hffff, 3, 2,
              16'hffff, 7);
    send_item(1'b1);
    repeat (3) send_item(1'b0);
    drain();

    // Shrink the destination mid-frame: row ends at once, residue may overshoot.
    configure(4095, 9, 300, 1, 5, 8, 3);
    send_item(1'b0);
    send_item(1'b0);
    drain();

    sent = 0;
    while (sent < RandomItems) begin
      phase_no++;
      calm = (phase_no == CalmPhase);
      configure(pick_src_dim(), pick_src_dim(), pick_stride(), pick_dst_dim(),
                pick_dst_dim(), pick_stride(), pick_channels());
      n = $urandom_range(60, 140);
      for (int i = 0; i < n; i++) begin
        if (i == 0)
          send_item($urandom_range(99) < 75);
        else
          send_item($urandom_range(99) < 3);
        sent++;
      end
      drain();
    end
    calm = 1'b0;

    repeat (32) @(posedge clk_i);
    if (board.pending() != 0)
      board.report_mismatch($sformatf("%0d results never arrived", board.pending()));
    if (board.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
